### rtl/spd_pkg.sv
`default_nettype none
package spd_pkg;

  localparam int unsigned MAX_LEN_DEFAULT = 128;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned DIST_W     = 33;
  localparam int unsigned OFS_W      = 5;
  localparam int unsigned OCNT_W     = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 33;

  // op codes of the input item
  localparam logic [OP_W-1:0] OP_APPEND_A = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND_B = 2'd1;
  localparam logic [OP_W-1:0] OP_EVAL     = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_SQ = 2'd2;

  localparam logic [OFS_W-1:0]  FIRST_OFFSET_RESET = 5'd0;
  localparam logic [OCNT_W-1:0] OFFSET_COUNT_RESET = 5'd10;
  localparam logic [DIST_W-1:0] THRESHOLD_RESET    = 33'd21233664;
  localparam logic [DIST_W-1:0] DIST_SAT           = {DIST_W{1'b1}};

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic eval_start;
    logic shift_load;
    logic shift_next;
    logic pair_issue;
    logic result_load;
  } spd_cmd_t;

  typedef struct packed {
    logic shift_done;
    logic shift_has_pairs;
    logic pair_last;
    logic pipe_empty;
  } spd_status_t;

endpackage
`default_nettype wire

### rtl/spd_if.sv
`default_nettype none
interface spd_in_if;
  logic                          valid;
  logic                          ready;
  logic [spd_pkg::OP_W-1:0]      op;
  logic [spd_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output op, output sample, input ready);
  modport sink (input valid, input op, input sample, output ready);
endinterface

interface spd_out_if;
  logic                        valid;
  logic                        ready;
  logic [spd_pkg::DIST_W-1:0]  distance_sq;
  logic                        dissimilar;
  logic                        no_match;
  logic                        overflow;

  modport source (output valid, output distance_sq, output dissimilar, output no_match,
                  output overflow, input ready);
  modport sink (input valid, input distance_sq, input dissimilar, input no_match,
                input overflow, output ready);
endinterface
`default_nettype wire

### rtl/spd_ram.sv
`default_nettype none
module spd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/spd_datapath.sv
`default_nettype none
module spd_datapath #(
  parameter int unsigned MAX_LEN = spd_pkg::MAX_LEN_DEFAULT
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [spd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [spd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [spd_pkg::SAMPLE_W-1:0]   sample_i,
  input  wire spd_pkg::spd_cmd_t              cmd_i,
  output spd_pkg::spd_status_t                status_o,
  output logic      [spd_pkg::DIST_W-1:0]     distance_sq_o,
  output logic                                dissimilar_o,
  output logic                                no_match_o,
  output logic                                overflow_o
);
  import spd_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  // pair indexes must also hold the start of a shift, up to 46
  localparam int unsigned IW = ((CW > 6) ? CW : 6) + 1;
  localparam int unsigned OW = 7;

  // configuration
  logic [OFS_W-1:0]  first_offset_q;
  logic [OCNT_W-1:0] offset_count_q;
  logic [DIST_W-1:0] threshold_q;

  // profile bookkeeping
  logic [CW-1:0] count_a_q, count_b_q;
  logic          dropped_q;

  // shift / pair sequencing
  logic [OCNT_W-1:0]   k_q;
  logic signed [OW-1:0] o_cur, o_q;
  logic [IW-1:0]        i_q, j_q, i0, j0, cnt_a_x, cnt_b_x;
  logic                 first_q;

  // pipeline
  logic                 s1_v_q, s1_first_q, s1_last_q;
  logic signed [OW-1:0] s1_o_q;
  logic                 s2_v_q, s2_first_q, s2_last_q;
  logic [31:0]          s2_sq_q;
  logic [11:0]          s2_osq_q;
  logic                 fold_v_q;
  logic [DIST_W-1:0]    worst_q, best_q;
  logic                 any_q;

  logic [SAMPLE_W-1:0]      rdata_a, rdata_b;
  logic signed [SAMPLE_W:0] dy;
  logic signed [33:0]       dy_sq;
  logic signed [13:0]       o_sq;
  logic [DIST_W-1:0]        d_s2, worst_d, dist_res;
  logic                     full_a, full_b, too_long;

  assign full_a   = (count_a_q == CW'(MAX_LEN));
  assign full_b   = (count_b_q == CW'(MAX_LEN));
  assign too_long = (count_b_q > count_a_q);
  assign cnt_a_x  = {{(IW-CW){1'b0}}, count_a_q};
  assign cnt_b_x  = {{(IW-CW){1'b0}}, count_b_q};

  assign o_cur = $signed({{(OW-OFS_W){first_offset_q[OFS_W-1]}}, first_offset_q})
               + $signed({{(OW-OCNT_W){1'b0}}, k_q});
  // negative shift starts A late, positive shift starts B late
  assign i0 = o_cur[OW-1] ? IW'(-o_cur) : '0;
  assign j0 = o_cur[OW-1] ? '0 : IW'(o_cur);

  assign status_o.shift_done      = too_long || (k_q == offset_count_q);
  assign status_o.shift_has_pairs = (i0 < cnt_a_x) && (j0 < cnt_b_x);
  assign status_o.pair_last       = (IW'(i_q + 1'b1) >= cnt_a_x) ||
                                    (IW'(j_q + 1'b1) >= cnt_b_x);
  assign status_o.pipe_empty      = !s1_v_q && !s2_v_q && !fold_v_q;

  spd_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_LEN)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_a && !full_a),
    .waddr_i (count_a_q[AW-1:0]),
    .wdata_i (sample_i),
    .raddr_i (i_q[AW-1:0]),
    .rdata_o (rdata_a)
  );

  spd_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_LEN)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_b && !full_b),
    .waddr_i (count_b_q[AW-1:0]),
    .wdata_i (sample_i),
    .raddr_i (j_q[AW-1:0]),
    .rdata_o (rdata_b)
  );

  assign dy    = $signed({1'b0, rdata_b}) - $signed({1'b0, rdata_a});
  assign dy_sq = dy * dy;
  assign o_sq  = s1_o_q * s1_o_q;

  assign d_s2    = DIST_W'({s2_osq_q, 16'b0}) + DIST_W'(s2_sq_q);
  assign worst_d = (s2_first_q || (d_s2 > worst_q)) ? d_s2 : worst_q;
  assign dist_res = any_q ? best_q : DIST_SAT;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_offset_q <= FIRST_OFFSET_RESET;
      offset_count_q <= OFFSET_COUNT_RESET;
      threshold_q    <= THRESHOLD_RESET;
      count_a_q      <= '0;
      count_b_q      <= '0;
      dropped_q      <= 1'b0;
      k_q            <= '0;
      s1_v_q         <= 1'b0;
      s2_v_q         <= 1'b0;
      fold_v_q       <= 1'b0;
      any_q          <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FIRST_OFFSET: first_offset_q <= cfg_data_i[OFS_W-1:0];
          REG_OFFSET_COUNT: offset_count_q <= cfg_data_i[OCNT_W-1:0];
          REG_THRESHOLD_SQ: threshold_q    <= cfg_data_i[DIST_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.load_a) begin
        if (full_a) dropped_q <= 1'b1;
        else        count_a_q <= CW'(count_a_q + 1'b1);
      end
      if (cmd_i.load_b) begin
        if (full_b) dropped_q <= 1'b1;
        else        count_b_q <= CW'(count_b_q + 1'b1);
      end
      if (cmd_i.result_load) begin
        count_a_q <= '0;
        count_b_q <= '0;
        dropped_q <= 1'b0;
      end
      if (cmd_i.eval_start) begin
        k_q   <= '0;
        any_q <= 1'b0;
      end else if (cmd_i.shift_next) begin
        k_q <= OCNT_W'(k_q + 1'b1);
      end
      s1_v_q   <= cmd_i.pair_issue;
      s2_v_q   <= s1_v_q;
      fold_v_q <= s2_v_q && s2_last_q;
      if (fold_v_q) begin
        any_q <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_load) begin
      i_q     <= i0;
      j_q     <= j0;
      o_q     <= o_cur;
      first_q <= 1'b1;
    end else if (cmd_i.pair_issue) begin
      i_q     <= IW'(i_q + 1'b1);
      j_q     <= IW'(j_q + 1'b1);
      first_q <= 1'b0;
    end
    s1_first_q <= first_q;
    s1_last_q  <= status_o.pair_last;
    s1_o_q     <= o_q;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_sq_q    <= dy_sq[31:0];
    s2_osq_q   <= o_sq[11:0];
    if (s2_v_q) begin
      worst_q <= worst_d;
    end
    if (fold_v_q && (!any_q || (worst_q < best_q))) begin
      best_q <= worst_q;
    end
    if (cmd_i.result_load) begin
      distance_sq_o <= dist_res;
      dissimilar_o  <= (dist_res > threshold_q);
      no_match_o    <= !any_q;
      overflow_o    <= dropped_q;
    end
  end

  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_a_q <= CW'(MAX_LEN)) && (count_b_q <= CW'(MAX_LEN)))
    else $error("profile count beyond capacity");

  a_issue_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pair_issue |-> ((i_q < cnt_a_x) && (j_q < cnt_b_x)))
    else $error("pair read outside stored samples");

  a_fold_sets_any: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fold_v_q |=> any_q)
    else $error("shift folded without marking a match");

endmodule
`default_nettype wire

### rtl/spd_ctrl.sv
`default_nettype none
module spd_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  input  wire logic [spd_pkg::OP_W-1:0]  in_op_i,
  output logic                           in_ready_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  input  wire spd_pkg::spd_status_t      status_i,
  output spd_pkg::spd_cmd_t              cmd_o
);
  import spd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_RUN,
    S_DRAIN,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_xfer, slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_o.load_a = (in_op_i == OP_APPEND_A);
          cmd_o.load_b = (in_op_i == OP_APPEND_B);
          if (in_op_i == OP_EVAL) begin
            cmd_o.eval_start = 1'b1;
            state_d          = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        if (status_i.shift_done) begin
          state_d = S_DRAIN;
        end else if (status_i.shift_has_pairs) begin
          cmd_o.shift_load = 1'b1;
          state_d          = S_RUN;
        end else begin
          // shift pairs nothing, skip it
          cmd_o.shift_next = 1'b1;
        end
      end
      S_RUN: begin
        cmd_o.pair_issue = 1'b1;
        if (status_i.pair_last) begin
          cmd_o.shift_next = 1'b1;
          state_d          = S_SHIFT;
        end
      end
      S_DRAIN: begin
        if (status_i.pipe_empty) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.result_load = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> status_i.pipe_empty)
    else $error("input taken while pair pipeline busy");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.result_load |=> out_valid_q)
    else $error("result loaded but not presented");

endmodule
`default_nettype wire

### rtl/shifted_profile_distance_top.sv
// channel   dir  transfer when          payload
// in_if     in   valid && ready         op, sample
// out_if    out  valid && ready         distance_sq, dissimilar, no_match, overflow
// cfg       in   cfg_we_i (no stall)    cfg_idx_i, cfg_data_i
//
// append items never stall the input; op code 3 is taken and ignored
// evaluate is paced by the pair sequencer, which reads one sample of each profile ram
// per cycle
// input is stalled from an evaluate transfer until its result is loaded
// the result sits in an output register; a stalled output blocks only the next evaluate end
// reset clears counts and flags and loads the configuration reset values; the profile rams need no clearing
`default_nettype none
module shifted_profile_distance_top #(
  parameter int unsigned MAX_LEN = spd_pkg::MAX_LEN_DEFAULT
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  spd_in_if.sink                              in_if,
  spd_out_if.source                           out_if,
  input  wire logic                           cfg_we_i,
  input  wire logic [spd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [spd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import spd_pkg::*;

  spd_cmd_t    cmd;
  spd_status_t status;
  logic        in_ready, out_valid;

  spd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_op_i     (in_if.op),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_if.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  spd_datapath #(.MAX_LEN(MAX_LEN)) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .sample_i      (in_if.sample),
    .cmd_i         (cmd),
    .status_o      (status),
    .distance_sq_o (out_if.distance_sq),
    .dissimilar_o  (out_if.dissimilar),
    .no_match_o    (out_if.no_match),
    .overflow_o    (out_if.overflow)
  );

  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;

endmodule
`default_nettype wire
